// ===== sv/cmod_pkg.sv =====
// ----------------------------------------------------------------------------
// cmod_pkg: shared types and constants for community modularity
// Word layouts of the input and result channels and the fixed field widths.
// ----------------------------------------------------------------------------
package cmod_pkg;

	// fixed field widths
	localparam int LABEL_W   = 4;
	localparam int Q_W       = 18;
	localparam int CFG_W     = 5;
	localparam int FRAC_BITS = 16;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int STEP_W    = $clog2(FRAC_BITS + 1);

	// community count after reset
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	// largest and smallest modularity in q16
	localparam logic signed [Q_W-1:0] Q_ONE     = Q_W'(65536);
	localparam logic signed [Q_W-1:0] Q_NEG_ONE = -Q_W'(65536);

	// one adjacency entry
	typedef struct packed {
		logic [LABEL_W-1:0] node_community;
		logic [LABEL_W-1:0] neighbour_community;
		logic               last_entry;
	} item_t;

	// one modularity result
	typedef struct packed {
		logic signed [Q_W-1:0] modularity_q16;
		logic                  label_error;
	} result_t;

endpackage

// ===== sv/cmod_frac.sv =====
// ----------------------------------------------------------------------------
// cmod_frac: fractional restoring divider
// Computes floor(mag * 2^16 / den) for mag <= den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cmod_frac #(
	parameter int DW = 42
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DW-1:0]                mag,
	input  logic [DW-1:0]                den,
	output logic                         done,
	output logic [cmod_pkg::QUO_W-1:0]   quo
);

	logic                              run_q;
	logic                              done_q;
	logic [cmod_pkg::STEP_W-1:0]       cnt_q;
	logic [DW-1:0]                     den_q;
	logic [DW-1:0]                     rem_q;
	logic [cmod_pkg::QUO_W-1:0]        quo_q;
	logic [DW:0]                       rem2;
	logic [DW:0]                       diff;
	logic                              ge;

	// one trial subtraction per step
	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = rem2 >= {1'b0, den_q};

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				den_q <= den;
				run_q <= 1'b1;
				cnt_q <= cmod_pkg::STEP_W'(cmod_pkg::FRAC_BITS);
				if (mag >= den) begin
					rem_q <= mag - den;
					quo_q <= cmod_pkg::QUO_W'(1);
				end else begin
					rem_q <= mag;
					quo_q <= '0;
				end
			end else if (run_q) begin
				rem_q <= ge ? diff[DW-1:0] : rem2[DW-1:0];
				quo_q <= {quo_q[cmod_pkg::QUO_W-2:0], ge};
				cnt_q <= cnt_q - cmod_pkg::STEP_W'(1);
				if (cnt_q == cmod_pkg::STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== sv/community_modularity.sv =====
// ----------------------------------------------------------------------------
// community_modularity: modularity of a labeled graph
// Counts adjacency words into a community pair matrix and, after the last
// word, returns the modularity in q16 together with a label error flag.
// ----------------------------------------------------------------------------
// An adjacency word is taken when start is high and busy is low. The cycle it
// is taken in reads its pair counter from the matrix memory, which has one read
// port and one write port, and the next cycle, with busy high, writes it back
// incremented if its labels are valid and the total is not saturated, so a new
// word cannot be taken before the previous one is written back. After a word
// marked last, one sweep walks the whole matrix, reading and zeroing each
// counter, closing each row in S_ROW_D, S_ROW_R and S_ROW_A on the shared
// multiplier, then one multiply for T^2 and a 17-step divider. The result then
// appears on result for a single cycle with result_strobe high; it is not held
// and cannot be stalled, so the receiver must take it in that cycle. After reset
// a clearing pass zeroes the matrix while busy is high; the community count
// register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module community_modularity #(
	parameter int MAX_COMMUNITIES = 16,
	parameter int COUNT_BITS      = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  cmod_pkg::item_t               item,
	output cmod_pkg::result_t             result,
	output logic                          result_strobe,
	input  logic                          cfg_we,
	input  logic [cmod_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam int ID_W    = $clog2(MAX_COMMUNITIES);
	localparam int ADDR_W  = 2 * ID_W;
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int NW0     = $clog2(MAX_COMMUNITIES + 1);
	localparam int NW      = (NW0 > cmod_pkg::CFG_W) ? NW0 : cmod_pkg::CFG_W;
	localparam int PROD_W  = 2 * COUNT_BITS;
	localparam logic [ID_W-1:0] LAST_ID = ID_W'(MAX_COMMUNITIES - 1);

	typedef enum logic [10:0] {
		S_CLR      = 11'b000_0000_0001,
		S_IDLE     = 11'b000_0000_0010,
		S_INC      = 11'b000_0000_0100,
		S_SW_RD    = 11'b000_0000_1000,
		S_SW_ACC   = 11'b000_0001_0000,
		S_ROW_D    = 11'b000_0010_0000,
		S_ROW_R    = 11'b000_0100_0000,
		S_ROW_A    = 11'b000_1000_0000,
		S_T_MUL    = 11'b001_0000_0000,
		S_DIV_GO   = 11'b010_0000_0000,
		S_DIV_WAIT = 11'b100_0000_0000
	} state_t;

	state_t                          state_q;
	logic [cmod_pkg::CFG_W-1:0]      cfg_q;
	logic [ID_W-1:0]                 i_q;
	logic [ID_W-1:0]                 j_q;
	logic [ADDR_W-1:0]               addr_q;
	logic                            last_q;
	logic                            count_q;
	logic [COUNT_BITS-1:0]           total_q;
	logic                            err_q;
	logic [COUNT_BITS-1:0]           row_q;
	logic [COUNT_BITS-1:0]           diag_q;
	logic [PROD_W-1:0]               prod_q;
	logic [PROD_W-1:0]               dsum_q;
	logic [PROD_W-1:0]               ssum_q;
	logic                            neg_q;
	cmod_pkg::result_t               result_q;
	logic                            strobe_q;
	logic [COUNT_BITS-1:0]           rdata_q;
	logic [COUNT_BITS-1:0]           mem [DEPTH];

	logic [NW-1:0]                   eff_n;
	logic                            lab_ok;
	logic                            i_in;
	logic                            j_in;
	logic [ADDR_W-1:0]               in_addr;
	logic [ADDR_W-1:0]               sweep_addr;
	logic [ADDR_W-1:0]               mem_raddr;
	logic [ADDR_W-1:0]               mem_waddr;
	logic [COUNT_BITS-1:0]           mem_wdata;
	logic                            mem_we;
	logic [COUNT_BITS-1:0]           mul_a;
	logic [COUNT_BITS-1:0]           mul_b;
	logic                            neg;
	logic [PROD_W-1:0]               diff;
	logic [PROD_W-1:0]               mag;
	logic                            div_start;
	logic                            div_done;
	logic [cmod_pkg::QUO_W-1:0]      div_quo;
	logic signed [cmod_pkg::Q_W-1:0] q_mag;

	// effective community count and label checks
	assign eff_n = (NW'(cfg_q) > NW'(MAX_COMMUNITIES)) ? NW'(MAX_COMMUNITIES) : NW'(cfg_q);
	assign lab_ok = (NW'(item.node_community) < eff_n) &&
		(NW'(item.neighbour_community) < eff_n);
	assign i_in = NW'(i_q) < eff_n;
	assign j_in = NW'(j_q) < eff_n;

	// matrix addressing
	assign in_addr    = {ID_W'(item.node_community), ID_W'(item.neighbour_community)};
	assign sweep_addr = {i_q, j_q};
	assign mem_raddr  = (state_q == S_IDLE) ? in_addr : sweep_addr;
	assign mem_waddr  = (state_q == S_INC) ? addr_q : sweep_addr;
	assign mem_wdata  = (state_q == S_INC) ? rdata_q + COUNT_BITS'(1) : '0;
	assign mem_we     = (state_q == S_CLR) || (state_q == S_SW_RD) ||
		((state_q == S_INC) && count_q);

	// pair count memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_ROW_D: begin
				mul_a = diag_q;
				mul_b = total_q;
			end
			S_ROW_R: begin
				mul_a = row_q;
				mul_b = row_q;
			end
			default: begin
				mul_a = total_q;
				mul_b = total_q;
			end
		endcase
	end

	// shared multiplier, registered product
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// sign and clamped magnitude of the numerator
	assign neg  = ssum_q > dsum_q;
	assign diff = neg ? ssum_q - dsum_q : dsum_q - ssum_q;
	assign mag  = (diff > prod_q) ? prod_q : diff;

	assign div_start = (state_q == S_DIV_GO) && (total_q != '0);
	assign q_mag     = cmod_pkg::Q_W'(div_quo);

	cmod_frac #(
		.DW (PROD_W)
	) u_frac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (mag),
		.den    (prod_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= cmod_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			i_q      <= '0;
			j_q      <= '0;
			addr_q   <= '0;
			last_q   <= 1'b0;
			count_q  <= 1'b0;
			total_q  <= '0;
			err_q    <= 1'b0;
			row_q    <= '0;
			diag_q   <= '0;
			dsum_q   <= '0;
			ssum_q   <= '0;
			neg_q    <= 1'b0;
			result_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				// zero the matrix after reset
				S_CLR: begin
					if (j_q == LAST_ID) begin
						j_q <= '0;
						if (i_q == LAST_ID) begin
							i_q     <= '0;
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + ID_W'(1);
						end
					end else begin
						j_q <= j_q + ID_W'(1);
					end
				end
				// take a word, read its counter
				S_IDLE: begin
					if (start) begin
						addr_q  <= in_addr;
						last_q  <= item.last_entry;
						count_q <= lab_ok && (total_q != '1);
						if (!lab_ok) begin
							err_q <= 1'b1;
						end
						state_q <= S_INC;
					end
				end
				// write back the incremented counter
				S_INC: begin
					if (count_q) begin
						total_q <= total_q + COUNT_BITS'(1);
					end
					if (last_q) begin
						i_q     <= '0;
						j_q     <= '0;
						row_q   <= '0;
						diag_q  <= '0;
						dsum_q  <= '0;
						ssum_q  <= '0;
						state_q <= S_SW_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SW_RD: begin
					state_q <= S_SW_ACC;
				end
				// row sum and diagonal pick
				S_SW_ACC: begin
					if (j_in) begin
						row_q <= row_q + rdata_q;
					end
					if (i_q == j_q) begin
						diag_q <= rdata_q;
					end
					if (j_q == LAST_ID) begin
						state_q <= S_ROW_D;
					end else begin
						j_q     <= j_q + ID_W'(1);
						state_q <= S_SW_RD;
					end
				end
				S_ROW_D: begin
					state_q <= S_ROW_R;
				end
				S_ROW_R: begin
					if (i_in) begin
						dsum_q <= dsum_q + prod_q;
					end
					state_q <= S_ROW_A;
				end
				// close the row
				S_ROW_A: begin
					if (i_in) begin
						ssum_q <= ssum_q + prod_q;
					end
					row_q  <= '0;
					diag_q <= '0;
					j_q    <= '0;
					if (i_q == LAST_ID) begin
						i_q     <= '0;
						state_q <= S_T_MUL;
					end else begin
						i_q     <= i_q + ID_W'(1);
						state_q <= S_SW_RD;
					end
				end
				S_T_MUL: begin
					state_q <= S_DIV_GO;
				end
				// start the divide, or finish an empty graph
				S_DIV_GO: begin
					neg_q <= neg;
					if (total_q == '0) begin
						result_q.modularity_q16 <= '0;
						result_q.label_error    <= err_q;
						strobe_q                <= 1'b1;
						err_q                   <= 1'b0;
						state_q                 <= S_IDLE;
					end else begin
						state_q <= S_DIV_WAIT;
					end
				end
				// deliver the result and start the next graph
				S_DIV_WAIT: begin
					if (div_done) begin
						result_q.modularity_q16 <= neg_q ? -q_mag : q_mag;
						result_q.label_error    <= err_q;
						strobe_q                <= 1'b1;
						total_q                 <= '0;
						err_q                   <= 1'b0;
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = state_q != S_IDLE;
	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

// ===== sv/cmod_chk.sv =====
// ----------------------------------------------------------------------------
// cmod_chk: port checker for community modularity
// Watches the handshake and result ports over time.
// ----------------------------------------------------------------------------
module cmod_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input cmod_pkg::item_t   item,
	input cmod_pkg::result_t result,
	input logic              result_strobe
);

	// a taken word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after taking a word");

	// a word that is not last frees the block after its read-modify-write
	a_mid_word_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.last_entry) |=> ##1 !busy)
		else $error("block still busy after a plain word");

	// a result follows work, never two in a row
	a_strobe_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy) && !$past(result_strobe))
		else $error("result strobe without preceding work");

	// modularity stays within plus and minus one
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (result.modularity_q16 <= cmod_pkg::Q_ONE) &&
			(result.modularity_q16 >= cmod_pkg::Q_NEG_ONE))
		else $error("modularity out of range");

endmodule

bind community_modularity cmod_chk u_cmod_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.item          (item),
	.result        (result),
	.result_strobe (result_strobe)
);
